// ----- src/htfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte step for the frame decoder.
package htfd_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_CRC_SEED   = 2'd0;
	localparam logic [1:0] REG_CRC_POLY   = 2'd1;
	localparam logic [1:0] REG_WORDS      = 2'd2;

	// Register reset values and the one-word setting
	localparam logic [7:0] CRC_SEED_RST   = 8'hFF;
	localparam logic [7:0] CRC_POLY_RST   = 8'h31;
	localparam logic [1:0] WORDS_RST      = 2'd2;
	localparam logic [1:0] WORDS_ONE      = 2'd1;

	// Conversion scales and offsets (hundredths)
	localparam logic [14:0] TEMP_C_SCALE  = 15'd17500;
	localparam logic [14:0] TEMP_C_OFFSET = 15'd4500;
	localparam logic [14:0] TEMP_F_SCALE  = 15'd31500;
	localparam logic [15:0] TEMP_F_OFFSET = 16'd4900;
	localparam logic [13:0] HUM_SCALE     = 14'd10000;

	// Byte positions inside a frame
	localparam logic [2:0] POS_LAST       = 3'd5;

	// Result handed from the frame parser to the output stage
	typedef struct packed {
		logic        emit;
		logic        fault;
		logic        two;
		logic [15:0] first_word;
		logic [15:0] second_word;
	} frame_res_t;

	// One CRC-8 byte update, MSB first, top polynomial bit implied
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- src/htfd_frame_parse.sv -----
// Frame parser: byte position, per-word CRC check and raw word capture.
module htfd_frame_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	input  logic [7:0]         crc_seed,
	input  logic [7:0]         crc_poly,
	input  logic [1:0]         words_per_frame,
	output htfd_pkg::frame_res_t res
);
	import htfd_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [7:0]  hi_q;
	logic [15:0] first_q;
	logic [15:0] second_q;
	logic        fault_q;

	logic [2:0]  pos;
	logic        clr;
	logic        widx;
	logic [1:0]  in_word;
	logic        two;
	logic        last_word;
	logic [2:0]  pos_n;
	logic [7:0]  crc_n;
	logic [7:0]  hi_n;
	logic [15:0] first_n;
	logic [15:0] second_n;
	logic        fault_n;

	// Decode the position of this byte in its frame
	always_comb begin
		pos     = (frame_start || pos_q > POS_LAST) ? 3'd0 : pos_q;
		clr     = (pos == 3'd0);
		widx    = (pos >= 3'd3);
		in_word = widx ? 2'(pos - 3'd3) : pos[1:0];
		two     = (words_per_frame != WORDS_ONE);
		last_word = widx || !two;
	end

	// Advance the frame state for one byte
	always_comb begin
		pos_n    = pos + 3'd1;
		crc_n    = crc_q;
		hi_n     = hi_q;
		first_n  = clr ? 16'd0 : first_q;
		second_n = clr ? 16'd0 : second_q;
		fault_n  = clr ? 1'b0 : fault_q;
		res      = '0;
		case (in_word)
			2'd0: begin
				crc_n = crc8_step(crc_seed, rx_byte, crc_poly);
				hi_n  = rx_byte;
			end
			2'd1: begin
				crc_n = crc8_step(crc_q, rx_byte, crc_poly);
				if (widx) begin
					second_n = {hi_q, rx_byte};
				end else begin
					first_n = {hi_q, rx_byte};
				end
			end
			default: begin
				fault_n = fault_n | (crc_q != rx_byte);
				if (last_word) begin
					pos_n           = 3'd0;
					res.emit        = 1'b1;
					res.fault       = fault_n;
					res.two         = two;
					res.first_word  = first_n;
					res.second_word = two ? second_n : 16'd0;
				end
			end
		endcase
	end

	// Hold state until a byte transaction is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			crc_q    <= CRC_SEED_RST;
			hi_q     <= 8'd0;
			first_q  <= 16'd0;
			second_q <= 16'd0;
			fault_q  <= 1'b0;
		end else if (step) begin
			pos_q    <= pos_n;
			crc_q    <= crc_n;
			hi_q     <= hi_n;
			first_q  <= first_n;
			second_q <= second_n;
			fault_q  <= fault_n;
		end
	end

endmodule

// ----- src/humidity_temp_frame_decoder_unit.sv -----
// Top level of the humidity/temperature response frame decoder.
//
//  channel  dir  payload
//  s_*      in   tdata: rx_byte[7:0]; tuser: frame_start
//  m_*      out  tdata: first_word, second_word, temp_c, temp_f, humidity; tuser: status
//  cfg_*    in   write of crc_seed (0), crc_polynomial (1), words_per_frame (2)
//
// One byte transaction per cycle is sustained while m_tready keeps up. A byte is
// registered, the parser and CRC step work on it, a finished frame is captured, then
// the constant-scale conversions feed the result register that drives m_tvalid.
// Reset clears the frame state and loads the register reset values. Each stage moves
// when the one after it is empty or moving, so a stalled result holds s_tready low only
// once all stages are full.
module humidity_temp_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	input  logic        s_tuser,    // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,    // [15:0] first_word, [31:16] second_word,
	                                // [46:32] temp_c_centi, [62:47] temp_f_centi,
	                                // [76:63] humidity_centi, [79:77] zero
	output logic        m_tuser,    // [0] frame_status
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import htfd_pkg::*;

	logic [7:0] seed_q;
	logic [7:0] poly_q;
	logic [1:0] words_q;

	logic       v1_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	logic       v2_s2;
	frame_res_t res_s2;

	logic       ready1;
	logic       ready2;
	logic       ready3;
	frame_res_t res;

	logic [30:0] prod_c;
	logic [30:0] prod_f;
	logic [29:0] prod_h;
	logic [14:0] temp_c;
	logic [15:0] temp_f;
	logic [13:0] hum;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= CRC_SEED_RST;
			poly_q  <= CRC_POLY_RST;
			words_q <= WORDS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CRC_SEED: seed_q  <= cfg_data;
				REG_CRC_POLY: poly_q  <= cfg_data;
				REG_WORDS:    words_q <= cfg_data[1:0];
				default:      ;
			endcase
		end
	end

	// Stage handshake chain
	assign ready3   = !m_tvalid || m_tready;
	assign ready2   = !v2_s2 || ready3;
	assign ready1   = !v1_s1 || ready2;
	assign s_tready = ready1;

	// Register the incoming byte transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (ready1) begin
			v1_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	htfd_frame_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (v1_s1 && ready2),
		.rx_byte         (byte_s1),
		.frame_start     (start_s1),
		.crc_seed        (seed_q),
		.crc_poly        (poly_q),
		.words_per_frame (words_q),
		.res             (res)
	);

	// Capture a finished frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (ready2) begin
			v2_s2 <= v1_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2 && v1_s1 && res.emit) begin
			res_s2 <= res;
		end
	end

	// Scale the raw words to hundredths, or give zeros when a frame has one word
	always_comb begin
		prod_c = 31'(res_s2.first_word) * 31'(TEMP_C_SCALE);
		prod_f = 31'(res_s2.first_word) * 31'(TEMP_F_SCALE);
		prod_h = 30'(res_s2.second_word) * 30'(HUM_SCALE);
		temp_c = prod_c[30:16] - TEMP_C_OFFSET;
		temp_f = {1'b0, prod_f[30:16]} - TEMP_F_OFFSET;
		hum    = prod_h[29:16];
		if (!res_s2.two) begin
			temp_c = 15'd0;
			temp_f = 16'd0;
			hum    = 14'd0;
		end
	end

	// Drive the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ready3) begin
			m_tvalid <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready3 && v2_s2) begin
			m_tdata <= {3'b000, hum, temp_f, temp_c, res_s2.second_word, res_s2.first_word};
			m_tuser <= res_s2.fault;
		end
	end

	// A frame leaving the capture stage lands in the result register
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && ready3 |=> m_tvalid)
		else $error("captured frame lost before result register");

	// A blocked input byte holds in its register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !ready2 |=> v1_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("input byte overwritten while blocked");

	// A new result comes only from a captured frame
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v2_s2))
		else $error("result appeared without a captured frame");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the frame decoder: directed table, then random frames per setting.
`timescale 1ns / 1ps

module tb_top;
	import htfd_pkg::*;

	// Register index past the end of the list; writes to it must be ignored
	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam int         TC_OFS      = -4500;
	localparam int         TF_OFS      = -4900;
	localparam int         TC_GAIN     = 17500;
	localparam int         TF_GAIN     = 31500;
	localparam int         HUM_GAIN    = 10000;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASE_BYTES = 210;
	localparam int         LONG_HOLD   = 120;

	typedef struct packed {
		logic               status;
		logic [15:0]        first_word;
		logic [15:0]        second_word;
		logic signed [14:0] temp_c;
		logic signed [15:0] temp_f;
		logic [13:0]        humidity;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]    data;
		logic          start;
		logic          typed;
		frame_result_t res;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] seed;
		logic [7:0] poly;
		logic [1:0] words;
		logic       spare;
		logic       steady;
		logic       rnd;
	} phase_cfg_t;

	localparam frame_result_t RES_NONE = '0;
	localparam frame_result_t RES_LOW  = '{status: 1'b0, first_word: 16'h0000,
		second_word: 16'h0000, temp_c: -15'sd4500, temp_f: -16'sd4900, humidity: 14'd0};
	localparam frame_result_t RES_HIGH = '{status: 1'b0, first_word: 16'hFFFF,
		second_word: 16'hFFFF, temp_c: 15'sd12999, temp_f: 16'sd26599, humidity: 14'd9999};
	localparam frame_result_t RES_BAD  = '{status: 1'b1, first_word: 16'h0000,
		second_word: 16'hFFFF, temp_c: -15'sd4500, temp_f: -16'sd4900, humidity: 14'd9999};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_data = 8'h00;

	// Predictor copy of the registers and frame state
	logic [7:0]  seed_reg = CRC_SEED_RST;
	logic [7:0]  poly_reg = CRC_POLY_RST;
	logic [1:0]  words_reg = WORDS_RST;
	logic [2:0]  frame_pos = 3'd0;
	logic [7:0]  crc_acc = CRC_SEED_RST;
	logic [7:0]  high_byte = 8'h00;
	logic [15:0] held_w0 = 16'h0000;
	logic [15:0] held_w1 = 16'h0000;
	logic        crc_bad = 1'b0;

	frame_result_t expected_frames[$];
	int unsigned   bytes_sent = 0;
	int unsigned   mismatches = 0;
	int unsigned   burst_left = 0;
	bit            steady_send = 1'b0;
	bit            long_hold_req = 1'b0;
	bit            long_hold_done = 1'b0;
	int unsigned   long_left = 0;
	logic [15:0]   stall_pat = '1;
	logic [3:0]    pat_idx = 4'd0;

	stim_row_t directed_rows [25] = '{
		// all-zero measurement frame with good CRCs
		'{8'h00, 1'b1, 1'b0, RES_NONE}, '{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h81, 1'b0, 1'b0, RES_NONE}, '{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE}, '{8'h81, 1'b0, 1'b1, RES_LOW},
		// all-ones measurement frame with good CRCs
		'{8'hFF, 1'b1, 1'b0, RES_NONE}, '{8'hFF, 1'b0, 1'b0, RES_NONE},
		'{8'hAC, 1'b0, 1'b0, RES_NONE}, '{8'hFF, 1'b0, 1'b0, RES_NONE},
		'{8'hFF, 1'b0, 1'b0, RES_NONE}, '{8'hAC, 1'b0, 1'b1, RES_HIGH},
		// no frame start after a finished frame, bad CRC on the second word
		'{8'h00, 1'b0, 1'b0, RES_NONE}, '{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h81, 1'b0, 1'b0, RES_NONE}, '{8'hFF, 1'b0, 1'b0, RES_NONE},
		'{8'hFF, 1'b0, 1'b0, RES_NONE}, '{8'h00, 1'b0, 1'b1, RES_BAD},
		// frame start in mid-frame drops the partial frame
		'{8'hBE, 1'b1, 1'b0, RES_NONE}, '{8'hBE, 1'b1, 1'b0, RES_NONE},
		'{8'hEF, 1'b0, 1'b0, RES_NONE}, '{8'h92, 1'b0, 1'b0, RES_NONE},
		'{8'h66, 1'b0, 1'b0, RES_NONE}, '{8'h66, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE}
	};

	phase_cfg_t phase_tab [7] = '{
		'{8'hFF, 8'h31, 2'd2, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 8'h31, 2'd1, 1'b0, 1'b1, 1'b0},
		'{8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 8'hFF, 2'd3, 1'b0, 1'b0, 1'b0},
		'{8'h00, 8'h00, 2'd1, 1'b0, 1'b0, 1'b1},
		'{8'h00, 8'h00, 2'd2, 1'b1, 1'b0, 1'b1},
		'{8'hFF, 8'h31, 2'd2, 1'b0, 1'b0, 1'b0}
	};

	humidity_temp_frame_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// CRC-8 over one byte, MSB first
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] acc;
		acc = crc ^ b;
		repeat (8) acc = (acc << 1) ^ (acc[7] ? poly : 8'h00);
		return acc;
	endfunction

	// Advance the frame state by one byte; return 1 when a frame result is due
	function automatic bit decode_byte(input logic [7:0] b, input logic st,
			output frame_result_t r);
		logic [2:0] p;
		bit         two;
		r = '0;
		p = frame_pos;
		two = (words_reg != WORDS_ONE);
		if (st || p > POS_LAST) p = 3'd0;
		if (p == 3'd0) begin
			crc_bad = 1'b0;
			held_w0 = '0;
			held_w1 = '0;
		end
		case (p % 3)
			0: begin
				crc_acc = crc8_next(seed_reg, b, poly_reg);
				high_byte = b;
				frame_pos = p + 3'd1;
				return 1'b0;
			end
			1: begin
				crc_acc = crc8_next(crc_acc, b, poly_reg);
				if (p < 3) held_w0 = {high_byte, b};
				else held_w1 = {high_byte, b};
				frame_pos = p + 3'd1;
				return 1'b0;
			end
			default: begin
				if (crc_acc != b) crc_bad = 1'b1;
				if (two && p < 3) begin
					frame_pos = p + 3'd1;
					return 1'b0;
				end
			end
		endcase
		frame_pos = 3'd0;
		r.status = crc_bad;
		r.first_word = held_w0;
		if (two) begin
			r.second_word = held_w1;
			r.temp_c = 15'(longint'(TC_OFS) + ((longint'(TC_GAIN) * held_w0) >> 16));
			r.temp_f = 16'(longint'(TF_OFS) + ((longint'(TF_GAIN) * held_w0) >> 16));
			r.humidity = 14'((longint'(HUM_GAIN) * held_w1) >> 16);
		end
		return 1'b1;
	endfunction

	// Offer one byte, hold until the transaction, then predict and maybe pause
	task automatic push_byte(input logic [7:0] b, input logic st, input bit typed,
			input frame_result_t typed_res);
		frame_result_t res;
		s_tdata <= b;
		s_tuser <= st;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (decode_byte(b, st, res)) expected_frames.push_back(typed ? typed_res : res);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady_send && $urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Write one register and mirror it in the predictor
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_CRC_SEED: seed_reg = val;
			REG_CRC_POLY: poly_reg = val;
			REG_WORDS:    words_reg = val[1:0];
			default: ;
		endcase
	endtask

	// Drop valid, wait for all expected results, then let the pipeline empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stall pattern, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (long_hold_req && !long_hold_done) begin
				long_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (long_left > 0) begin
				long_left--;
				m_tready <= 1'b0;
			end else begin
				if (pat_idx == 4'd0) begin
					stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
						: (16'($urandom) | 16'($urandom));
				end
				m_tready <= stall_pat[pat_idx];
				pat_idx = pat_idx + 4'd1;
			end
		end
	end

	// Compare each result transaction with the oldest expected frame
	always @(posedge clk) begin : result_check
		frame_result_t seen;
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.status = m_tuser;
			seen.first_word = m_tdata[15:0];
			seen.second_word = m_tdata[31:16];
			seen.temp_c = m_tdata[46:32];
			seen.temp_f = m_tdata[62:47];
			seen.humidity = m_tdata[76:63];
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result status=%0b w0=%h w1=%h",
						seen.status, seen.first_word, seen.second_word);
			end else begin
				want = expected_frames.pop_front();
				if (seen != want || m_tdata[79:77] != 3'b000) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: expected status=%0b w0=%h w1=%h c=%0d f=%0d h=%0d",
							want.status, want.first_word, want.second_word,
							want.temp_c, want.temp_f, want.humidity);
						$display("       actual   status=%0b w0=%h w1=%h c=%0d f=%0d h=%0d pad=%b",
							seen.status, seen.first_word, seen.second_word,
							seen.temp_c, seen.temp_f, seen.humidity, m_tdata[79:77]);
					end
				end
			end
		end
	end

	// Run limit
	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

	// Stimulus
	initial begin
		int unsigned   k;
		int unsigned   w;
		int unsigned   n;
		int unsigned   target;
		int unsigned   nwords;
		logic [15:0]   word;
		logic [7:0]    chk;
		logic          st;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table under reset settings
		for (k = 0; k < 25; k++) begin
			push_byte(directed_rows[k].data, directed_rows[k].start, directed_rows[k].typed,
				directed_rows[k].res);
		end

		for (int phase = 0; phase < 7; phase++) begin
			// Reconfigure only with the block idle
			if (phase != 0) begin
				wait_drained();
				write_reg(REG_CRC_SEED, phase_tab[phase].rnd ? 8'($urandom) : phase_tab[phase].seed);
				write_reg(REG_CRC_POLY, phase_tab[phase].rnd ? 8'($urandom) : phase_tab[phase].poly);
				if (phase_tab[phase].spare) write_reg(REG_SPARE, 8'($urandom));
				write_reg(REG_WORDS, phase_tab[phase].words);
				cfg_wr_en <= 1'b0;
			end
			steady_send = phase_tab[phase].steady;
			if (phase_tab[phase].steady) long_hold_req = 1'b1;

			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 99) < 85) begin
					// Well-formed frame, mostly good CRCs
					nwords = (words_reg == WORDS_ONE) ? 1 : 2;
					for (w = 0; w < nwords; w++) begin
						if ($urandom_range(0, 7) == 0)
							word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
						else
							word = 16'($urandom);
						chk = crc8_next(crc8_next(seed_reg, word[15:8], poly_reg), word[7:0],
							poly_reg);
						if ($urandom_range(0, 6) == 0) chk = 8'($urandom);
						st = (w == 0) && ((frame_pos != 3'd0) || ($urandom_range(0, 1) == 1));
						push_byte(word[15:8], st, 1'b0, '0);
						push_byte(word[7:0], 1'b0, 1'b0, '0);
						push_byte(chk, 1'b0, 1'b0, '0);
					end
				end else begin
					// Noise: short runs of random bytes with stray frame starts
					n = $urandom_range(1, 5);
					for (k = 0; k < n; k++)
						push_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, '0);
				end
			end
			steady_send = 1'b0;
		end

		wait_drained();
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- humidity_temp_frame_decoder_unit.f -----
src/htfd_pkg.sv
src/htfd_frame_parse.sv
src/humidity_temp_frame_decoder_unit.sv
verif/tb_top.sv
